@@ src/maze_wall_union_find_macros.svh @@
// Assertion macros shared by the checker of the maze wall union-find block.
// No dependencies; the user supplies a clock named clock and a reset named reset.
`ifndef MAZE_WALL_UNION_FIND_MACROS_SVH
`define MAZE_WALL_UNION_FIND_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define MWUF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define MWUF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/mwuf_pkg.sv @@
// Package of the maze wall union-find block: field widths, register codes,
// controller states, and the command and status structs. No dependencies.
package mwuf_pkg;

   localparam int unsigned DIM_W      = 6;
   localparam int unsigned WALL_W     = 11;
   localparam int unsigned ROOM_OUT_W = 10;
   localparam int unsigned WALLS_W    = 2 * DIM_W + 1;
   localparam int unsigned PL_W       = DIM_W + 1;
   localparam int unsigned PROD_W     = WALL_W + DIM_W;
   localparam int unsigned DIV_CNT_W  = $clog2(WALL_W);
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

   typedef enum logic {
      REG_ROW_COUNT = 1'b0,
      REG_COL_COUNT = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_ROOMS,
      ST_FIND_START,
      ST_FIND_A,
      ST_FIND_B,
      ST_UNITE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_FIRST,
      RD_SECOND,
      RD_FOLLOW
   } rd_sel_type;

   typedef struct packed {
      logic       wall_load;
      logic       check;
      logic       div_init;
      logic       div_step;
      logic       map_mul;
      logic       map_rooms;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       root_a_save;
      logic       root_b_save;
      logic       unite;
      logic       rsp_load;
      logic       clr_init;
      logic       clr_run;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic root_hit;
      logic clr_last;
   } status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (32'(v) > maxv) begin
         return DIM_W'(maxv);
      end
      return v;
   endfunction

endpackage

@@ src/maze_wall_union_find.sv @@
// Top level of the maze wall union-find block: configuration registers and the
// controller and datapath instances. Depends on mwuf_pkg, mwuf_ctrl and mwuf_dp.
//
// Each item on the req_ channel is a wall index of the configured room grid.
// The block maps it to its two rooms, finds both rooms' sets in a disjoint-set
// store and, when they differ, merges them and reports the wall as removed.
// Exactly one rsp_ item comes out per item taken in and not cut off by a CSR write.
// A wall index at or beyond the grid's wall count gives bad_wall with zero rooms.
// The time from acceptance to rsp_valid grows with dA and dB, the link depths
// walked from the two rooms to their set roots; union by rank keeps each depth
// at or below log2 of the room count (10 for 32 x 32). A bad wall skips the
// divider and both root searches. The eleven-step divider and the single read
// port of the parent memory set how long a good item takes.
// Reset and every write to row_count or col_count start a clearing pass over all
// MAX_ROWS*MAX_COLS entries (1024 by default), during which req_ready stays low.
// A finished item waits in the output register while rsp_ready is low; a new
// item is still accepted and the block stops only when it has a second result.
module maze_wall_union_find #(
   parameter int unsigned MAX_ROWS = 32,
   parameter int unsigned MAX_COLS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mwuf_pkg::WALL_W-1:0]         req_wall_num,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mwuf_pkg::ROOM_OUT_W-1:0]     rsp_first_room,
   output logic [mwuf_pkg::ROOM_OUT_W-1:0]     rsp_second_room,
   output logic                                rsp_removed,
   output logic                                rsp_bad_wall,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mwuf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mwuf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mwuf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [mwuf_pkg::DIM_W-1:0] row_count_ff;
   logic [mwuf_pkg::DIM_W-1:0] col_count_ff;
   logic                       cfg_wr;
   mwuf_pkg::reg_index_type    reg_index;
   mwuf_pkg::cmd_type          cmd;
   mwuf_pkg::status_type       status;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = mwuf_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= mwuf_pkg::DIM_RESET;
         col_count_ff <= mwuf_pkg::DIM_RESET;
      end else if (cfg_wr) begin
         unique case (reg_index)
            mwuf_pkg::REG_ROW_COUNT: row_count_ff <= csr_pwdata[mwuf_pkg::DIM_W-1:0];
            mwuf_pkg::REG_COL_COUNT: col_count_ff <= csr_pwdata[mwuf_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         mwuf_pkg::REG_ROW_COUNT: csr_prdata = mwuf_pkg::CSR_DATA_W'(row_count_ff);
         mwuf_pkg::REG_COL_COUNT: csr_prdata = mwuf_pkg::CSR_DATA_W'(col_count_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   mwuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cfg_wr    (cfg_wr),
      .status    (status),
      .cmd       (cmd)
   );

   mwuf_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .row_count   (row_count_ff),
      .col_count   (col_count_ff),
      .wall_num    (req_wall_num),
      .cmd         (cmd),
      .status      (status),
      .first_room  (rsp_first_room),
      .second_room (rsp_second_room),
      .removed     (rsp_removed),
      .bad_wall    (rsp_bad_wall)
   );

endmodule

@@ src/mwuf_ctrl.sv @@
// Controller of the maze wall union-find block: sequences clearing, division,
// room mapping, the two root searches and the merge. Depends on mwuf_pkg.
module mwuf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  cfg_wr,
   input  mwuf_pkg::status_type  status,
   output mwuf_pkg::cmd_type     cmd
);

   mwuf_pkg::state_type                  state_ff;
   mwuf_pkg::state_type                  state_in;
   logic [mwuf_pkg::DIV_CNT_W-1:0]       div_cnt_ff;
   logic [mwuf_pkg::DIV_CNT_W-1:0]       div_cnt_in;
   logic                                 div_last;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic                                 slot_free;

   assign div_last  = div_cnt_ff == mwuf_pkg::DIV_CNT_W'(mwuf_pkg::WALL_W - 1);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == mwuf_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwuf_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = mwuf_pkg::ST_IDLE;
         end
         mwuf_pkg::ST_IDLE: begin
            if (req_valid) state_in = mwuf_pkg::ST_CHECK;
         end
         mwuf_pkg::ST_CHECK: begin
            state_in = status.bad ? mwuf_pkg::ST_DONE : mwuf_pkg::ST_DIV;
         end
         mwuf_pkg::ST_DIV: begin
            if (div_last) state_in = mwuf_pkg::ST_MUL;
         end
         mwuf_pkg::ST_MUL:        state_in = mwuf_pkg::ST_ROOMS;
         mwuf_pkg::ST_ROOMS:      state_in = mwuf_pkg::ST_FIND_START;
         mwuf_pkg::ST_FIND_START: state_in = mwuf_pkg::ST_FIND_A;
         mwuf_pkg::ST_FIND_A: begin
            if (status.root_hit) state_in = mwuf_pkg::ST_FIND_B;
         end
         mwuf_pkg::ST_FIND_B: begin
            if (status.root_hit) state_in = mwuf_pkg::ST_UNITE;
         end
         mwuf_pkg::ST_UNITE:      state_in = mwuf_pkg::ST_DONE;
         mwuf_pkg::ST_DONE: begin
            if (slot_free) state_in = mwuf_pkg::ST_IDLE;
         end
         default:                 state_in = mwuf_pkg::ST_CLEAR;
      endcase
      if (cfg_wr) state_in = mwuf_pkg::ST_CLEAR;
   end

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = mwuf_pkg::RD_FOLLOW;
      cmd.clr_init = cfg_wr;
      unique case (state_ff)
         mwuf_pkg::ST_CLEAR: begin
            cmd.clr_run = !cfg_wr;
         end
         mwuf_pkg::ST_IDLE: begin
            cmd.wall_load = req_valid;
         end
         mwuf_pkg::ST_CHECK: begin
            cmd.check    = 1'b1;
            cmd.div_init = 1'b1;
         end
         mwuf_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         mwuf_pkg::ST_MUL: begin
            cmd.map_mul = 1'b1;
         end
         mwuf_pkg::ST_ROOMS: begin
            cmd.map_rooms = 1'b1;
         end
         mwuf_pkg::ST_FIND_START: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = mwuf_pkg::RD_FIRST;
         end
         mwuf_pkg::ST_FIND_A: begin
            cmd.rd_en       = 1'b1;
            cmd.root_a_save = status.root_hit;
            cmd.rd_sel      = status.root_hit ? mwuf_pkg::RD_SECOND : mwuf_pkg::RD_FOLLOW;
         end
         mwuf_pkg::ST_FIND_B: begin
            cmd.rd_en       = !status.root_hit;
            cmd.root_b_save = status.root_hit;
         end
         mwuf_pkg::ST_UNITE: begin
            cmd.unite = 1'b1;
         end
         mwuf_pkg::ST_DONE: begin
            cmd.rsp_load = slot_free;
         end
         default: begin
            cmd.clr_init = 1'b1;
         end
      endcase
   end

   always_comb begin
      div_cnt_in = div_cnt_ff;
      if (state_ff == mwuf_pkg::ST_CHECK) begin
         div_cnt_in = '0;
      end else if (state_ff == mwuf_pkg::ST_DIV) begin
         div_cnt_in = div_cnt_ff + mwuf_pkg::DIV_CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwuf_pkg::ST_CLEAR;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/mwuf_dp.sv @@
// Datapath of the maze wall union-find block: grid geometry, bit-serial divider,
// room mapping, parent and rank memories, result register. Depends on mwuf_pkg.
module mwuf_dp #(
   parameter int unsigned MAX_ROWS = 32,
   parameter int unsigned MAX_COLS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [mwuf_pkg::DIM_W-1:0]         row_count,
   input  logic [mwuf_pkg::DIM_W-1:0]         col_count,
   input  logic [mwuf_pkg::WALL_W-1:0]        wall_num,
   input  mwuf_pkg::cmd_type                  cmd,
   output mwuf_pkg::status_type               status,
   output logic [mwuf_pkg::ROOM_OUT_W-1:0]    first_room,
   output logic [mwuf_pkg::ROOM_OUT_W-1:0]    second_room,
   output logic                               removed,
   output logic                               bad_wall
);

   localparam int unsigned ROOM_CAP = MAX_ROWS * MAX_COLS;
   localparam int unsigned ROOM_W   = (ROOM_CAP > 1) ? $clog2(ROOM_CAP) : 1;
   localparam int unsigned RANK_W   = $clog2(ROOM_W + 1);

   logic [mwuf_pkg::DIM_W-1:0]      rows_c;
   logic [mwuf_pkg::DIM_W-1:0]      cols_c;
   logic [2*mwuf_pkg::DIM_W-1:0]    rooms_c;
   logic [mwuf_pkg::DIM_W-1:0]      cols_ff;
   logic [mwuf_pkg::DIM_W-1:0]      cols_m1_ff;
   logic [mwuf_pkg::PL_W-1:0]       per_line_ff;
   logic [mwuf_pkg::WALLS_W-1:0]    walls_ff;

   logic [mwuf_pkg::WALL_W-1:0]     wall_ff;
   logic                            bad_ff;
   logic [mwuf_pkg::PL_W-1:0]       rem_ff;
   logic [mwuf_pkg::WALL_W-1:0]     quo_ff;
   logic [mwuf_pkg::PL_W:0]         rem_sh;
   logic                            div_ge;
   logic [mwuf_pkg::PROD_W-1:0]     prod_ff;
   logic                            pos_lt;
   logic [mwuf_pkg::PROD_W-1:0]     first_sum;
   logic [mwuf_pkg::PROD_W-1:0]     second_sum;
   logic [ROOM_W-1:0]               first_ff;
   logic [ROOM_W-1:0]               second_ff;

   logic [ROOM_W-1:0]               parent_mem [ROOM_CAP];
   logic [RANK_W-1:0]               rank_mem [ROOM_CAP];
   logic [ROOM_W-1:0]               rd_addr;
   logic [ROOM_W-1:0]               cur_ff;
   logic [ROOM_W-1:0]               par_rd_ff;
   logic [RANK_W-1:0]               rank_rd_ff;
   logic [ROOM_W-1:0]               root_a_ff;
   logic [ROOM_W-1:0]               root_b_ff;
   logic [RANK_W-1:0]               rank_a_ff;
   logic [RANK_W-1:0]               rank_b_ff;
   logic                            merged_ff;
   logic [ROOM_W-1:0]               clr_cnt_ff;

   logic                            par_we;
   logic [ROOM_W-1:0]               par_waddr;
   logic [ROOM_W-1:0]               par_wdata;
   logic                            rank_we;
   logic [ROOM_W-1:0]               rank_waddr;
   logic [RANK_W-1:0]               rank_wdata;

   logic [mwuf_pkg::ROOM_OUT_W-1:0] first_out_ff;
   logic [mwuf_pkg::ROOM_OUT_W-1:0] second_out_ff;
   logic                            removed_out_ff;
   logic                            bad_out_ff;

   assign rows_c  = mwuf_pkg::clamp_dim(row_count, MAX_ROWS);
   assign cols_c  = mwuf_pkg::clamp_dim(col_count, MAX_COLS);
   assign rooms_c = (2*mwuf_pkg::DIM_W)'(rows_c) * (2*mwuf_pkg::DIM_W)'(cols_c);

   // The wall count is 2*rows*cols - rows - cols.
   always_ff @(posedge clock) begin
      cols_ff     <= cols_c;
      cols_m1_ff  <= cols_c - mwuf_pkg::DIM_W'(1);
      per_line_ff <= {cols_c, 1'b0} - mwuf_pkg::PL_W'(1);
      walls_ff    <= {rooms_c, 1'b0} - mwuf_pkg::WALLS_W'(rows_c)
                     - mwuf_pkg::WALLS_W'(cols_c);
   end

   assign status.bad = mwuf_pkg::WALLS_W'(wall_ff) >= walls_ff;

   assign rem_sh = {rem_ff, quo_ff[mwuf_pkg::WALL_W-1]};
   assign div_ge = rem_sh >= {1'b0, per_line_ff};

   always_ff @(posedge clock) begin
      if (cmd.wall_load) begin
         wall_ff <= wall_num;
      end
      if (cmd.check) begin
         bad_ff <= status.bad;
      end
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= wall_ff;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? mwuf_pkg::PL_W'(rem_sh - {1'b0, per_line_ff})
                          : rem_sh[mwuf_pkg::PL_W-1:0];
         quo_ff <= {quo_ff[mwuf_pkg::WALL_W-2:0], div_ge};
      end
      if (cmd.map_mul) begin
         prod_ff <= mwuf_pkg::PROD_W'(quo_ff) * mwuf_pkg::PROD_W'(cols_ff);
      end
      if (cmd.map_rooms) begin
         first_ff  <= ROOM_W'(first_sum);
         second_ff <= ROOM_W'(second_sum);
      end
   end

   // A position before cols-1 is a vertical wall; the rest of the line are floors.
   assign pos_lt     = rem_ff < mwuf_pkg::PL_W'(cols_m1_ff);
   assign first_sum  = pos_lt ? prod_ff + mwuf_pkg::PROD_W'(rem_ff)
                              : prod_ff + mwuf_pkg::PROD_W'(rem_ff)
                                - mwuf_pkg::PROD_W'(cols_m1_ff);
   assign second_sum = first_sum + (pos_lt ? mwuf_pkg::PROD_W'(1)
                                           : mwuf_pkg::PROD_W'(cols_ff));

   always_comb begin
      case (cmd.rd_sel)
         mwuf_pkg::RD_FIRST:  rd_addr = first_ff;
         mwuf_pkg::RD_SECOND: rd_addr = second_ff;
         default:             rd_addr = par_rd_ff;
      endcase
   end

   assign status.root_hit = par_rd_ff == cur_ff;
   assign status.clr_last = clr_cnt_ff == ROOM_W'(ROOM_CAP - 1);

   // Union by rank keeps every tree no deeper than log2 of the room count.
   always_comb begin
      par_we     = 1'b0;
      par_waddr  = root_b_ff;
      par_wdata  = root_a_ff;
      rank_we    = 1'b0;
      rank_waddr = root_a_ff;
      rank_wdata = rank_a_ff + RANK_W'(1);
      if (cmd.clr_run) begin
         par_we     = 1'b1;
         par_waddr  = clr_cnt_ff;
         par_wdata  = clr_cnt_ff;
         rank_we    = 1'b1;
         rank_waddr = clr_cnt_ff;
         rank_wdata = '0;
      end else if (cmd.unite && (root_a_ff != root_b_ff)) begin
         par_we = 1'b1;
         if (rank_a_ff < rank_b_ff) begin
            par_waddr = root_a_ff;
            par_wdata = root_b_ff;
         end else begin
            rank_we = rank_a_ff == rank_b_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         parent_mem[par_waddr] <= par_wdata;
      end
      if (cmd.rd_en) begin
         par_rd_ff <= parent_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
      if (cmd.rd_en) begin
         rank_rd_ff <= rank_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         cur_ff <= rd_addr;
      end
      if (cmd.root_a_save) begin
         root_a_ff <= cur_ff;
         rank_a_ff <= rank_rd_ff;
      end
      if (cmd.root_b_save) begin
         root_b_ff <= cur_ff;
         rank_b_ff <= rank_rd_ff;
      end
      if (cmd.unite) begin
         merged_ff <= root_a_ff != root_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_init) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_run) begin
         clr_cnt_ff <= clr_cnt_ff + ROOM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         first_out_ff   <= bad_ff ? '0 : mwuf_pkg::ROOM_OUT_W'(first_ff);
         second_out_ff  <= bad_ff ? '0 : mwuf_pkg::ROOM_OUT_W'(second_ff);
         removed_out_ff <= merged_ff && !bad_ff;
         bad_out_ff     <= bad_ff;
      end
   end

   assign first_room  = first_out_ff;
   assign second_room = second_out_ff;
   assign removed     = removed_out_ff;
   assign bad_wall    = bad_out_ff;

endmodule

@@ src/mwuf_checker.sv @@
// Port-level checker of the maze wall union-find block and its bind statement.
// Depends on mwuf_pkg and maze_wall_union_find_macros.svh.
`include "maze_wall_union_find_macros.svh"

module mwuf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mwuf_pkg::ROOM_OUT_W-1:0]     rsp_first_room,
   input logic [mwuf_pkg::ROOM_OUT_W-1:0]     rsp_second_room,
   input logic                                rsp_removed,
   input logic                                rsp_bad_wall,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite
);

   logic [2*mwuf_pkg::ROOM_OUT_W-1:0] rsp_rooms;
   logic [2*mwuf_pkg::ROOM_OUT_W+1:0] rsp_item;
   logic                              rsp_stall;
   logic                              bad_item;
   logic                              good_item;
   logic                              cfg_write;

   assign rsp_rooms = {rsp_first_room, rsp_second_room};
   assign rsp_item  = {rsp_rooms, rsp_removed, rsp_bad_wall};
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign bad_item  = rsp_valid && rsp_bad_wall;
   assign good_item = rsp_valid && !rsp_bad_wall;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;

   `MWUF_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_item), "Stalled item changed")
   `MWUF_ASSERT(a_bad_clean, bad_item |-> rsp_rooms == '0 && !rsp_removed, "Bad wall with rooms")
   `MWUF_ASSERT(a_rooms_differ, good_item |-> rsp_first_room != rsp_second_room, "Rooms equal")
   `MWUF_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !req_ready, "Item taken after reset")
   `MWUF_ASSERT(a_cfg_clears, cfg_write |=> !req_ready, "Item taken after a register write")

endmodule

bind maze_wall_union_find mwuf_checker u_mwuf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_first_room  (rsp_first_room),
   .rsp_second_room (rsp_second_room),
   .rsp_removed     (rsp_removed),
   .rsp_bad_wall    (rsp_bad_wall),
   .csr_psel        (csr_psel),
   .csr_penable     (csr_penable),
   .csr_pwrite      (csr_pwrite)
);
